/* rtl/ews_pkg.sv */
package ews_pkg;

    // Wheels served by this build, and the wheel fields on the channels.
    localparam int WHEEL_COUNT = 4;
    localparam int MAX_WHEELS  = 4;
    localparam int WHEEL_IDX_W = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;

    localparam int COUNT_W = 16;
    localparam int TIME_W  = 32;
    localparam int RPM_W   = 16;
    localparam int CPR_W   = 16;

    // Divider operands: |delta| * 60000 fits 31 bits, cpr * dt needs 48.
    localparam int NUM_W   = 31;
    localparam int DEN_W   = CPR_W + TIME_W;
    localparam int STEP_W  = $clog2(NUM_W);

    localparam logic [15:0]       RPM_SCALE   = 16'd60000;
    localparam logic [RPM_W-1:0]  RPM_MAX     = 16'h7FFF;
    localparam logic [RPM_W-1:0]  RPM_MIN_MAG = 16'h8000;
    localparam logic [CPR_W-1:0]  CPR_RESET   = 16'd1024;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_STORE,
        ST_DONE
    } ews_state_t;

endpackage

/* rtl/ews_if.sv */
interface ews_in_if;
    logic                          valid;
    logic                          ready;
    logic [ews_pkg::TIME_W-1:0]    now_ms;
    logic [ews_pkg::COUNT_W-1:0]   count_wheel0;
    logic [ews_pkg::COUNT_W-1:0]   count_wheel1;
    logic [ews_pkg::COUNT_W-1:0]   count_wheel2;
    logic [ews_pkg::COUNT_W-1:0]   count_wheel3;

    modport source (output valid, now_ms, count_wheel0, count_wheel1, count_wheel2,
                    count_wheel3, input ready);
    modport sink   (input valid, now_ms, count_wheel0, count_wheel1, count_wheel2,
                    count_wheel3, output ready);
endinterface

interface ews_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [ews_pkg::RPM_W-1:0]   rpm_wheel0;
    logic signed [ews_pkg::RPM_W-1:0]   rpm_wheel1;
    logic signed [ews_pkg::RPM_W-1:0]   rpm_wheel2;
    logic signed [ews_pkg::RPM_W-1:0]   rpm_wheel3;

    modport source (output valid, rpm_wheel0, rpm_wheel1, rpm_wheel2, rpm_wheel3,
                    input ready);
    modport sink   (input valid, rpm_wheel0, rpm_wheel1, rpm_wheel2, rpm_wheel3,
                    output ready);
endinterface

interface ews_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ews_pkg::CPR_W-1:0]     counts_per_rev;

    modport source (output valid, counts_per_rev, input ready);
    modport sink   (input valid, counts_per_rev, output ready);
endinterface

/* rtl/encoder_wheel_speed_estimator.sv */
// Channel  | Dir | Payload                                   | Accepted when
// ---------+-----+-------------------------------------------+----------------------------
// cfg      | in  | counts_per_rev (16b, 0 acts as 1)         | cfg.valid && cfg.ready
// samples  | in  | now_ms (32b), count_wheel0..3 (16b)       | samples.valid && samples.ready
// speeds   | out | rpm_wheel0..3 (16b signed, saturated)     | speeds.valid && speeds.ready
//
// One beat in yields one beat out. With elapsed time, the sequencer first forms cpr * dt,
// then per wheel loads |delta| * 60000 into the shared bit-serial divider, waits for the
// quotient, and saturates and stores it. A beat with no elapsed time repeats the held
// speeds. samples.ready is high only while the sequencer is idle; a finished beat waits
// in the output register, so a new sample may enter while speeds stalls. Reset: cpr 1024,
// state 0.
module encoder_wheel_speed_estimator (
    input  logic       clk,
    input  logic       rst_n,
    ews_cfg_if.sink    cfg,
    ews_in_if.sink     samples,
    ews_out_if.source  speeds
);

    ews_pkg::ews_state_t state_reg, state_next;

    // configuration
    logic [ews_pkg::CPR_W-1:0]  cpr_reg;
    logic [ews_pkg::CPR_W-1:0]  cpr_eff;

    // architectural state
    logic [ews_pkg::COUNT_W-1:0]      prev_count_reg [ews_pkg::WHEEL_COUNT];
    logic signed [ews_pkg::RPM_W-1:0] held_reg       [ews_pkg::WHEEL_COUNT];
    logic [ews_pkg::TIME_W-1:0]       prev_time_reg;

    // per-beat working registers
    logic [ews_pkg::COUNT_W-1:0]  cur_count_reg [ews_pkg::WHEEL_COUNT];
    logic [ews_pkg::TIME_W-1:0]   now_reg;
    logic [ews_pkg::TIME_W-1:0]   dt_reg;
    logic [ews_pkg::DEN_W-1:0]    den_reg;
    logic [ews_pkg::WHEEL_IDX_W-1:0] wheel_reg;
    logic                         neg_reg;

    // output register
    logic                              out_valid_reg, out_valid_next;
    logic signed [ews_pkg::RPM_W-1:0]  rpm_out_reg [ews_pkg::MAX_WHEELS];

    // sequencer strobes
    logic accept, do_mul, do_load, do_store, do_out, last_wheel;

    // wheel datapath
    logic [ews_pkg::COUNT_W-1:0]       in_count [ews_pkg::MAX_WHEELS];
    logic signed [ews_pkg::RPM_W-1:0]  held_full [ews_pkg::MAX_WHEELS];
    logic [ews_pkg::COUNT_W-1:0]       diff;
    logic [ews_pkg::COUNT_W-1:0]       mag;
    logic [31:0]                       prod;
    logic [ews_pkg::TIME_W-1:0]        dt_next;
    logic                              div_last;
    logic [ews_pkg::NUM_W-1:0]         div_quot;
    logic [ews_pkg::RPM_W-1:0]         mag_sat;
    logic signed [ews_pkg::RPM_W-1:0]  rpm_sat;

    assign cfg.ready     = 1'b1;
    assign cpr_eff       = (cpr_reg == '0) ? ews_pkg::CPR_W'(1) : cpr_reg;

    assign samples.ready = (state_reg == ews_pkg::ST_IDLE);
    assign accept        = samples.valid && samples.ready;
    assign dt_next       = samples.now_ms - prev_time_reg;

    assign in_count[0] = samples.count_wheel0;
    assign in_count[1] = samples.count_wheel1;
    assign in_count[2] = samples.count_wheel2;
    assign in_count[3] = samples.count_wheel3;

    // wheel delta, sign and magnitude; 0x8000 negates to itself as 32768
    assign diff = cur_count_reg[wheel_reg] - prev_count_reg[wheel_reg];
    assign mag  = diff[ews_pkg::COUNT_W-1] ? (~diff + 1'b1) : diff;
    assign prod = mag * ews_pkg::RPM_SCALE;

    ews_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (do_load),
        .num   (prod[ews_pkg::NUM_W-1:0]),
        .den   (den_reg),
        .last  (div_last),
        .quot  (div_quot)
    );

    // saturate: positive side to 32767, negative magnitude to 32768
    always_comb
    begin
        if (neg_reg)
        begin
            mag_sat = (div_quot > ews_pkg::NUM_W'(ews_pkg::RPM_MIN_MAG))
                      ? ews_pkg::RPM_MIN_MAG : div_quot[ews_pkg::RPM_W-1:0];
            rpm_sat = $signed(ews_pkg::RPM_W'(0) - mag_sat);
        end
        else
        begin
            mag_sat = (div_quot > ews_pkg::NUM_W'(ews_pkg::RPM_MAX))
                      ? ews_pkg::RPM_MAX : div_quot[ews_pkg::RPM_W-1:0];
            rpm_sat = $signed(mag_sat);
        end
    end

    assign last_wheel = (wheel_reg == ews_pkg::WHEEL_IDX_W'(ews_pkg::WHEEL_COUNT - 1));

    // unused wheel fields read as zero
    for (genvar i = 0; i < ews_pkg::MAX_WHEELS; i++)
    begin : g_held
        if (i < ews_pkg::WHEEL_COUNT)
        begin : g_used
            assign held_full[i] = held_reg[i];
        end
        else
        begin : g_unused
            assign held_full[i] = '0;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ews_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        do_mul     = 1'b0;
        do_load    = 1'b0;
        do_store   = 1'b0;
        do_out     = 1'b0;
        unique case (state_reg)
            ews_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = (dt_next == '0) ? ews_pkg::ST_DONE : ews_pkg::ST_MUL;
            end
            ews_pkg::ST_MUL:
            begin
                do_mul     = 1'b1;
                state_next = ews_pkg::ST_LOAD;
            end
            ews_pkg::ST_LOAD:
            begin
                do_load    = 1'b1;
                state_next = ews_pkg::ST_DIV;
            end
            ews_pkg::ST_DIV:
            begin
                if (div_last)
                    state_next = ews_pkg::ST_STORE;
            end
            ews_pkg::ST_STORE:
            begin
                do_store   = 1'b1;
                state_next = last_wheel ? ews_pkg::ST_DONE : ews_pkg::ST_LOAD;
            end
            ews_pkg::ST_DONE:
            begin
                if (!out_valid_reg || speeds.ready)
                begin
                    do_out     = 1'b1;
                    state_next = ews_pkg::ST_IDLE;
                end
            end
            default:
                state_next = ews_pkg::ST_IDLE;
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpr_reg       <= ews_pkg::CPR_RESET;
            prev_time_reg <= '0;
            wheel_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ews_pkg::WHEEL_COUNT; i++)
            begin
                prev_count_reg[i] <= '0;
                held_reg[i]       <= '0;
            end
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                cpr_reg <= cfg.counts_per_rev;
            out_valid_reg <= out_valid_next;
            if (accept)
                wheel_reg <= '0;
            else if (do_store && !last_wheel)
                wheel_reg <= wheel_reg + 1'b1;
            if (do_store)
            begin
                held_reg[wheel_reg]       <= rpm_sat;
                prev_count_reg[wheel_reg] <= cur_count_reg[wheel_reg];
                if (last_wheel)
                    prev_time_reg <= now_reg;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (do_out)
            out_valid_next = 1'b1;
        else if (speeds.ready)
            out_valid_next = 1'b0;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg <= samples.now_ms;
            dt_reg  <= dt_next;
            for (int i = 0; i < ews_pkg::WHEEL_COUNT; i++)
                cur_count_reg[i] <= in_count[i];
        end
        if (do_mul)
            den_reg <= cpr_eff * dt_reg;
        if (do_load)
            neg_reg <= diff[ews_pkg::COUNT_W-1];
        if (do_out)
            for (int i = 0; i < ews_pkg::MAX_WHEELS; i++)
                rpm_out_reg[i] <= held_full[i];
    end

    assign speeds.valid      = out_valid_reg;
    assign speeds.rpm_wheel0 = rpm_out_reg[0];
    assign speeds.rpm_wheel1 = rpm_out_reg[1];
    assign speeds.rpm_wheel2 = rpm_out_reg[2];
    assign speeds.rpm_wheel3 = rpm_out_reg[3];

`ifndef SYNTH
    // a taken sample closes the input until the sequencer is back to idle
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !samples.ready)
        else $error("sample taken while a beat is in work");

    // divider finishes only while the sequencer waits on it
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_last |-> (state_reg == ews_pkg::ST_DIV))
        else $error("divider finished outside the divide state");

    // a result appears only from the done state
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ews_pkg::ST_DONE))
        else $error("result raised outside the done state");

    // wheel index stays within the wheels in use
    a_wheel_range: assert property (@(posedge clk) disable iff (!rst_n)
        wheel_reg <= ews_pkg::WHEEL_IDX_W'(ews_pkg::WHEEL_COUNT - 1))
        else $error("wheel index out of range");
`endif

endmodule

/* rtl/ews_div.sv */
// Restoring divider, one quotient bit per cycle, MSB first.
module ews_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ews_pkg::NUM_W-1:0]    num,
    input  logic [ews_pkg::DEN_W-1:0]    den,
    output logic                         last,
    output logic [ews_pkg::NUM_W-1:0]    quot
);

    logic                          busy_reg, busy_next;
    logic [ews_pkg::STEP_W-1:0]    cnt_reg, cnt_next;
    logic [ews_pkg::DEN_W-1:0]     rem_reg, rem_next;
    logic [ews_pkg::NUM_W-1:0]     quo_reg, quo_next;
    logic [ews_pkg::DEN_W:0]       trial;
    logic                          fits;

    assign trial = {rem_reg, quo_reg[ews_pkg::NUM_W-1]};
    assign fits  = trial >= {1'b0, den};
    assign last  = busy_reg && (cnt_reg == '0);
    assign quot  = quo_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = ews_pkg::STEP_W'(ews_pkg::NUM_W - 1);
            rem_next  = '0;
            quo_next  = num;
        end
        else if (busy_reg)
        begin
            // remainder stays below den, so the difference fits DEN_W bits
            rem_next  = fits ? ews_pkg::DEN_W'(trial - {1'b0, den})
                             : trial[ews_pkg::DEN_W-1:0];
            quo_next  = {quo_reg[ews_pkg::NUM_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

endmodule
